[hdl/ddpg_pkg.sv]
// Shared types and constants for the default-deny packet gate.
// No dependencies.
package ddpg_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_PROT  = 2'd1,
    REQ_ALLOW = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    RSN_SHORT   = 3'd0,
    RSN_CARVE   = 3'd1,
    RSN_UNPROT  = 3'd2,
    RSN_ICMP    = 3'd3,
    RSN_ALLOWED = 3'd4,
    RSN_NOPORTS = 3'd5,
    RSN_NOENTRY = 3'd6,
    RSN_EXPIRED = 3'd7
  } rsn_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_PRD,
    ST_PCHK,
    ST_ARD,
    ST_ACHK
  } state_e;

  localparam logic [2:0] CFG_SPA    = 3'd0;
  localparam logic [2:0] CFG_TUNNEL = 3'd1;
  localparam logic [2:0] CFG_SHELL  = 3'd2;
  localparam logic [2:0] CFG_ICMP   = 3'd3;
  localparam logic [2:0] CFG_TICK   = 3'd4;

  localparam logic [2:0] WI_CTRL  = 3'd4;
  localparam logic [2:0] WI_EXPLO = 3'd5;
  localparam logic [2:0] WI_EXPHI = 3'd6;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PR_ICMP  = 8'd1;
  localparam logic [7:0]  PR_TCP   = 8'd6;
  localparam logic [7:0]  PR_UDP   = 8'd17;
  localparam logic [7:0]  PR_ICMP6 = 8'd58;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pkt_byte;
    logic        pkt_last;
    logic [11:0] entry_index;
    logic [2:0]  word_index;
    logic [31:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic       drop;
    logic [2:0] reason;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic pwrite;
    logic awrite;
    logic tick;
    logic clr_hdr;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic       early;
    logic [2:0] early_rsn;
    logic       ports;
    logic       icmp_ok;
    logic       p_hit;
    logic       a_hit;
    logic       a_expired;
  } status_t;

endpackage

[hdl/default_deny_packet_gate.sv]
// Top level of the default-deny packet gate.
// Depends on ddpg_pkg, ddpg_ctrl, ddpg_dp.
//
//  channel   ports                           transfer
//  input     start, busy, in_item            start && !busy
//  result    out_strobe, out_item            out_strobe (one cycle)
//  config    cfg_we, cfg_index, cfg_data     cfg_we
//
// Frame bytes, table words and ticks leave busy low; the last byte of a frame
// raises it while the frame is classified and, as needed, the protected entries and
// then the allow entries are scanned (one memory read, one compare per entry); each
// scan stops at its first hit and the verdict is registered. After reset a clearing
// pass over max(PROTECTED_ENTRIES, ALLOW_ENTRIES) entries holds busy; config
// writes are taken meanwhile.
// Results cannot be stalled.
module default_deny_packet_gate #(
  parameter int PROTECTED_ENTRIES = 256,
  parameter int ALLOW_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ddpg_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output ddpg_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ddpg_pkg::*;

  localparam int MAXN = (PROTECTED_ENTRIES > ALLOW_ENTRIES) ? PROTECTED_ENTRIES
                                                            : ALLOW_ENTRIES;
  localparam int CW = $clog2(MAXN + 1);

  cmd_t          cmd;
  status_t       st;
  logic [CW-1:0] idx;

  ddpg_ctrl #(.PN(PROTECTED_ENTRIES), .AN(ALLOW_ENTRIES), .CW(CW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start),
    .req_type(in_item.req_type), .pkt_last(in_item.pkt_last),
    .st(st), .cmd(cmd), .idx(idx), .busy(busy),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  ddpg_dp #(.PN(PROTECTED_ENTRIES), .AN(ALLOW_ENTRIES), .CW(CW)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .idx(idx),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .st(st)
  );

endmodule

[hdl/ddpg_ctrl.sv]
// Sequencer for the packet gate: clearing sweep, item dispatch, table scans, verdict register.
// Depends on ddpg_pkg.
module ddpg_ctrl #(
  parameter int PN = 256,
  parameter int AN = 4096,
  parameter int CW = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  logic                pkt_last,
  input  ddpg_pkg::status_t   st,
  output ddpg_pkg::cmd_t      cmd,
  output logic [CW-1:0]       idx,
  output logic                busy,
  output logic                out_strobe,
  output ddpg_pkg::out_item_t out_item
);
  import ddpg_pkg::*;

  localparam int MAXN = (PN > AN) ? PN : AN;

  state_e     state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [2:0] rsn_r, rsn_nxt;
  logic       acc;

  assign busy = (state_r != ST_IDLE);
  assign acc  = start && !busy;
  assign idx  = idx_r;
  assign out_strobe = ov_r;
  assign out_item.reason = rsn_r;
  assign out_item.drop = (rsn_r == RSN_NOPORTS) || (rsn_r == RSN_NOENTRY) ||
                         (rsn_r == RSN_EXPIRED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      rsn_r   <= RSN_SHORT;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
      rsn_r   <= rsn_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    rsn_nxt   = rsn_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (32'(idx_r) == MAXN - 1) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (req_type)
            REQ_BYTE: begin
              cmd.capture = 1'b1;
              if (pkt_last) state_nxt = ST_EVAL;
            end
            REQ_PROT:  cmd.pwrite = 1'b1;
            REQ_ALLOW: cmd.awrite = 1'b1;
            REQ_TICK:  cmd.tick = 1'b1;
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        idx_nxt = '0;
        if (st.early) begin
          rsn_nxt = st.early_rsn;
          ov_nxt = 1'b1;
          cmd.clr_hdr = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: state_nxt = ST_PCHK;
      ST_PCHK: begin
        if (st.p_hit) begin
          idx_nxt = '0;
          if (st.ports) begin
            state_nxt = ST_ARD;
          end else begin
            rsn_nxt = st.icmp_ok ? RSN_ICMP : RSN_NOPORTS;
            ov_nxt = 1'b1;
            cmd.clr_hdr = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (32'(idx_r) == PN - 1) begin
          idx_nxt = '0;
          rsn_nxt = RSN_UNPROT;
          ov_nxt = 1'b1;
          cmd.clr_hdr = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_PRD;
        end
      end
      ST_ARD: state_nxt = ST_ACHK;
      ST_ACHK: begin
        if (st.a_hit || 32'(idx_r) == AN - 1) begin
          idx_nxt = '0;
          rsn_nxt = !st.a_hit ? RSN_NOENTRY : (st.a_expired ? RSN_EXPIRED : RSN_ALLOWED);
          ov_nxt = 1'b1;
          cmd.clr_hdr = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_ARD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hdl/ddpg_dp.sv]
// Datapath of the packet gate: config registers, clock, header capture, tables, match logic.
// Depends on ddpg_pkg.
module ddpg_dp #(
  parameter int PN = 256,
  parameter int AN = 4096,
  parameter int CW = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ddpg_pkg::in_item_t in_item,
  input  ddpg_pkg::cmd_t     cmd,
  input  logic [CW-1:0]      idx,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output ddpg_pkg::status_t  st
);
  import ddpg_pkg::*;

  localparam int PAW = (PN > 1) ? $clog2(PN) : 1;
  localparam int AAW = (AN > 1) ? $clog2(AN) : 1;

  // configuration and clock
  logic [15:0] spa_r, tun_r, shell_r;
  logic        icmp_r;
  logic [31:0] tick_r;
  logic [63:0] clk_ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spa_r    <= 16'd62201;
      tun_r    <= 16'd41641;
      shell_r  <= 16'd22;
      icmp_r   <= 1'b0;
      tick_r   <= 32'd1;
      clk_ns_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPA:    spa_r <= cfg_data[15:0];
          CFG_TUNNEL: tun_r <= cfg_data[15:0];
          CFG_SHELL:  shell_r <= cfg_data[15:0];
          CFG_ICMP:   icmp_r <= cfg_data[0];
          CFG_TICK:   tick_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.tick) clk_ns_r <= clk_ns_r + 64'(tick_r);
    end
  end

  // header capture
  logic [6:0]   cnt_r;
  logic [15:0]  eth_r;
  logic [3:0]   ihl_r;
  logic [7:0]   proto_r;
  logic [12:0]  frag_r;
  logic [15:0]  dport_r;
  logic [127:0] src_r, dst_r;
  logic [7:0]   b;
  logic [6:0]   p, l4c;
  logic [3:0]   k6s, k6d;

  assign b   = in_item.pkt_byte;
  assign p   = cnt_r;
  assign l4c = 7'd14 + {1'b0, ihl_r, 2'b00};
  assign k6s = 4'(p - 7'd22);
  assign k6d = 4'(p - 7'd38);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_hdr) begin
      cnt_r <= '0; eth_r <= '0; ihl_r <= '0; proto_r <= '0;
      frag_r <= '0; dport_r <= '0; src_r <= '0; dst_r <= '0;
    end else if (cmd.capture && cnt_r != 7'd127) begin
      cnt_r <= cnt_r + 7'd1;
      if (p == 7'd12) eth_r[15:8] <= b;
      else if (p == 7'd13) eth_r[7:0] <= b;
      else if (eth_r == ETH_IPV4) begin
        if (p == 7'd14) ihl_r <= b[3:0];
        else if (p == 7'd20) frag_r[12:8] <= b[4:0];
        else if (p == 7'd21) frag_r[7:0] <= b;
        else if (p == 7'd23) proto_r <= b;
        else if (p >= 7'd26 && p <= 7'd29) src_r[127 - 8*(p - 7'd26) -: 8] <= b;
        else if (p >= 7'd30 && p <= 7'd33) dst_r[127 - 8*(p - 7'd30) -: 8] <= b;
        if (p >= 7'd34 && p == l4c + 7'd2) dport_r[15:8] <= b;
        if (p >= 7'd34 && p == l4c + 7'd3) dport_r[7:0] <= b;
      end else if (eth_r == ETH_IPV6) begin
        if (p == 7'd20) proto_r <= b;
        else if (p >= 7'd22 && p <= 7'd37) src_r[127 - 8*k6s -: 8] <= b;
        else if (p >= 7'd38 && p <= 7'd53) dst_r[127 - 8*k6d -: 8] <= b;
        else if (p == 7'd56) dport_r[15:8] <= b;
        else if (p == 7'd57) dport_r[7:0] <= b;
      end
    end
  end

  // frame classification
  logic       is4, is6, v6, trunc, ports, carve;
  logic [7:0] l4, len;

  assign len = {1'b0, cnt_r};
  assign is4 = (eth_r == ETH_IPV4);
  assign is6 = (eth_r == ETH_IPV6);
  assign v6  = is6;
  assign l4  = is6 ? 8'd54 : {1'b0, l4c};
  always_comb begin
    trunc = 1'b0;
    if (len < 8'd14 || (!is4 && !is6)) trunc = 1'b1;
    else if (is4 && (len < 8'd34 || ihl_r < 4'd5 || {1'b0, l4c} > len)) trunc = 1'b1;
    else if (is6 && len < 8'd54) trunc = 1'b1;
    ports = 1'b0;
    if (!(is4 && frag_r != '0)) begin
      if (proto_r == PR_TCP && len >= l4 + 8'd20) ports = 1'b1;
      if (proto_r == PR_UDP && len >= l4 + 8'd8) ports = 1'b1;
    end
    carve = ports && ((proto_r == PR_UDP && (dport_r == spa_r || dport_r == tun_r)) ||
                      (proto_r == PR_TCP && dport_r == shell_r));
  end

  assign st.early     = trunc || carve;
  assign st.early_rsn = trunc ? RSN_SHORT : RSN_CARVE;
  assign st.ports     = ports;
  assign st.icmp_ok   = icmp_r && (proto_r == (v6 ? PR_ICMP6 : PR_ICMP));

  // tables
  logic [31:0]    ent32, idx32;
  logic [2:0]     wi;
  logic [31:0]    val;
  logic           pw, aw, pclr, aclr;
  logic [PAW-1:0] pwa;
  logic [AAW-1:0] awa;

  assign ent32 = 32'(in_item.entry_index);
  assign idx32 = 32'(idx);
  assign wi    = in_item.word_index;
  assign val   = in_item.word_value;
  assign pw    = cmd.pwrite && ent32 < PN && wi <= WI_CTRL;
  assign aw    = cmd.awrite && ent32 < AN && wi <= WI_EXPHI;
  assign pclr  = cmd.clear && idx32 < PN;
  assign aclr  = cmd.clear && idx32 < AN;
  assign pwa   = pclr ? idx[PAW-1:0] : ent32[PAW-1:0];
  assign awa   = aclr ? idx[AAW-1:0] : ent32[AAW-1:0];

  logic [31:0] p_addr_mem [4][PN];
  logic [31:0] a_addr_mem [4][AN];
  logic [1:0]  p_ctl_mem [PN];
  logic [25:0] a_ctl_mem [AN];
  logic [31:0] a_exp_mem [2][AN];
  logic [31:0] p_addr_q [4];
  logic [31:0] a_addr_q [4];
  logic [1:0]  p_ctl_q;
  logic [25:0] a_ctl_q;
  logic [31:0] a_exp_q [2];

  for (genvar k = 0; k < 4; k++) begin : g_addr
    always_ff @(posedge clk) begin
      if (pclr) p_addr_mem[k][pwa] <= '0;
      else if (pw && wi == 3'(k)) p_addr_mem[k][pwa] <= val;
      if (aclr) a_addr_mem[k][awa] <= '0;
      else if (aw && wi == 3'(k)) a_addr_mem[k][awa] <= val;
      p_addr_q[k] <= p_addr_mem[k][idx[PAW-1:0]];
      a_addr_q[k] <= a_addr_mem[k][idx[AAW-1:0]];
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_exp
    always_ff @(posedge clk) begin
      if (aclr) a_exp_mem[k][awa] <= '0;
      else if (aw && wi == WI_EXPLO + 3'(k)) a_exp_mem[k][awa] <= val;
      a_exp_q[k] <= a_exp_mem[k][idx[AAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pclr) p_ctl_mem[pwa] <= '0;
    else if (pw && wi == WI_CTRL) p_ctl_mem[pwa] <= val[25:24];
    if (aclr) a_ctl_mem[awa] <= '0;
    else if (aw && wi == WI_CTRL) a_ctl_mem[awa] <= val[25:0];
    p_ctl_q <= p_ctl_mem[idx[PAW-1:0]];
    a_ctl_q <= a_ctl_mem[idx[AAW-1:0]];
  end

  logic [127:0] p_key, a_key;
  logic [63:0]  a_exp;
  logic         p_aeq, a_aeq;

  assign p_key = {p_addr_q[0], p_addr_q[1], p_addr_q[2], p_addr_q[3]};
  assign a_key = {a_addr_q[0], a_addr_q[1], a_addr_q[2], a_addr_q[3]};
  assign a_exp = {a_exp_q[1], a_exp_q[0]};
  // IPv4 keys compare only the top address word
  assign p_aeq = v6 ? (p_key == dst_r) : (p_key[127:96] == dst_r[127:96]);
  assign a_aeq = v6 ? (a_key == src_r) : (a_key[127:96] == src_r[127:96]);

  assign st.p_hit = p_ctl_q[1] && (p_ctl_q[0] == v6) && p_aeq;
  assign st.a_hit = a_ctl_q[25] && (a_ctl_q[24] == v6) && (a_ctl_q[23:16] == proto_r) &&
                    (a_ctl_q[15:0] == dport_r) && a_aeq;
  assign st.a_expired = (a_exp != '0) && (clk_ns_r > a_exp);

endmodule

[hdl/ddpg_checker.sv]
// Port-level checks for the packet gate, bound to the top level.
// Depends on ddpg_pkg and default_deny_packet_gate.
module ddpg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ddpg_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input ddpg_pkg::out_item_t out_item
);
  import ddpg_pkg::*;

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("verdict repeated");

  a_idle_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy with verdict");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.req_type == REQ_BYTE && in_item.pkt_last) |=> busy)
    else $error("last byte did not start evaluation");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.req_type != REQ_BYTE) |=> !out_strobe)
    else $error("verdict without frame");

  a_drop_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.drop == (out_item.reason == RSN_NOPORTS ||
      out_item.reason == RSN_NOENTRY || out_item.reason == RSN_EXPIRED)))
    else $error("drop disagrees with reason");

endmodule

bind default_deny_packet_gate ddpg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_strobe(out_strobe), .out_item(out_item)
);

[tb/sv/default_deny_packet_gate_tb.sv]
// Self-checking testbench for default_deny_packet_gate: drives frames, table words,
// ticks and register writes, and checks every verdict against an in-bench predictor.
// Depends on ddpg_pkg and the default_deny_packet_gate RTL.
module default_deny_packet_gate_tb;
  import ddpg_pkg::*;

  localparam int P_ENTRIES = 256;
  localparam int A_ENTRIES = 4096;
  localparam int SCAN_CYCLES = 1 + 2 * P_ENTRIES + 2 * A_ENTRIES + 2;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int N_ITEMS = 1650;

  // Verdict predictor and store of expected verdicts.
  class gate_scoreboard;
    logic [15:0] spa, tunnel, shell;
    logic        icmp_en;
    logic [31:0] tick_step;
    logic [63:0] clk_ns;
    int unsigned nbytes;
    logic [15:0] eth, dport;
    logic [3:0]  ihl;
    logic [12:0] frag;
    logic [7:0]  proto;
    logic [127:0] src, dst;
    logic [127:0] p_addr[P_ENTRIES];
    bit           p_fam[P_ENTRIES], p_val[P_ENTRIES];
    logic [127:0] a_addr[A_ENTRIES];
    logic [15:0]  a_dport[A_ENTRIES];
    logic [7:0]   a_proto[A_ENTRIES];
    bit           a_fam[A_ENTRIES], a_val[A_ENTRIES];
    logic [63:0]  a_exp[A_ENTRIES];
    out_item_t    verdicts[$];
    int           errors, seen;

    function new();
      spa = 16'd62201; tunnel = 16'd41641; shell = 16'd22;
      icmp_en = 1'b0; tick_step = 32'd1; clk_ns = '0;
      errors = 0; seen = 0;
      for (int i = 0; i < P_ENTRIES; i++) begin
        p_addr[i] = '0; p_fam[i] = 0; p_val[i] = 0;
      end
      for (int i = 0; i < A_ENTRIES; i++) begin
        a_addr[i] = '0; a_dport[i] = '0; a_proto[i] = '0;
        a_fam[i] = 0; a_val[i] = 0; a_exp[i] = '0;
      end
      clear_frame();
    endfunction

    function void clear_frame();
      nbytes = 0; eth = '0; dport = '0; ihl = '0; frag = '0; proto = '0;
      src = '0; dst = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_SPA:    spa = v[15:0];
        CFG_TUNNEL: tunnel = v[15:0];
        CFG_SHELL:  shell = v[15:0];
        CFG_ICMP:   icmp_en = v[0];
        CFG_TICK:   tick_step = v;
        default: ;
      endcase
    endfunction

    function void capture(int p, logic [7:0] b);
      int l4;
      l4 = 14 + ihl * 4;
      if (p == 12) eth[15:8] = b;
      else if (p == 13) eth[7:0] = b;
      else if (eth == ETH_IPV4) begin
        if (p == 14) ihl = b[3:0];
        else if (p == 20) frag[12:8] = b[4:0];
        else if (p == 21) frag[7:0] = b;
        else if (p == 23) proto = b;
        else if (p >= 26 && p <= 29) src[127 - 8 * (p - 26) -: 8] = b;
        else if (p >= 30 && p <= 33) dst[127 - 8 * (p - 30) -: 8] = b;
        // dport offset follows the ihl captured so far
        if (p >= 34 && p == l4 + 2) dport[15:8] = b;
        if (p >= 34 && p == l4 + 3) dport[7:0] = b;
      end else if (eth == ETH_IPV6) begin
        if (p == 20) proto = b;
        else if (p >= 22 && p <= 37) src[127 - 8 * (p - 22) -: 8] = b;
        else if (p >= 38 && p <= 53) dst[127 - 8 * (p - 38) -: 8] = b;
        else if (p == 56) dport[15:8] = b;
        else if (p == 57) dport[7:0] = b;
      end
    endfunction

    function bit addr_match(bit v6, logic [127:0] a, logic [127:0] b);
      return v6 ? (a == b) : (a[127:96] == b[127:96]);
    endfunction

    function rsn_e verdict(int len);
      bit v6, ports, nofrag;
      int l4, hit;
      if (len < 14) return RSN_SHORT;
      nofrag = 0;
      if (eth == ETH_IPV4) begin
        if (len < 34 || ihl < 5 || 14 + ihl * 4 > len) return RSN_SHORT;
        v6 = 0; l4 = 14 + ihl * 4; nofrag = (frag != 0);
      end else if (eth == ETH_IPV6) begin
        if (len < 54) return RSN_SHORT;
        v6 = 1; l4 = 54;
      end else return RSN_SHORT;
      ports = !nofrag && ((proto == PR_TCP && len >= l4 + 20) ||
                          (proto == PR_UDP && len >= l4 + 8));
      if (ports) begin
        if (proto == PR_UDP && (dport == spa || dport == tunnel)) return RSN_CARVE;
        if (proto == PR_TCP && dport == shell) return RSN_CARVE;
      end
      hit = -1;
      for (int i = 0; i < P_ENTRIES && hit < 0; i++)
        if (p_val[i] && p_fam[i] == v6 && addr_match(v6, p_addr[i], dst)) hit = i;
      if (hit < 0) return RSN_UNPROT;
      if (!ports) begin
        if (icmp_en && proto == (v6 ? PR_ICMP6 : PR_ICMP)) return RSN_ICMP;
        return RSN_NOPORTS;
      end
      for (int i = 0; i < A_ENTRIES; i++)
        if (a_val[i] && a_fam[i] == v6 && a_proto[i] == proto && a_dport[i] == dport &&
            addr_match(v6, a_addr[i], src)) begin
          if (a_exp[i] != 0 && clk_ns > a_exp[i]) return RSN_EXPIRED;
          return RSN_ALLOWED;
        end
      return RSN_NOENTRY;
    endfunction

    function void note_input(in_item_t it);
      int e, w;
      out_item_t v;
      rsn_e r;
      e = it.entry_index; w = it.word_index;
      case (it.req_type)
        REQ_TICK: clk_ns = clk_ns + tick_step;
        REQ_PROT: if (e < P_ENTRIES && w <= 4) begin
          if (w < 4) p_addr[e][127 - 32 * w -: 32] = it.word_value;
          else begin
            p_fam[e] = it.word_value[24]; p_val[e] = it.word_value[25];
          end
        end
        REQ_ALLOW: if (e < A_ENTRIES && w <= 6) begin
          if (w < 4) a_addr[e][127 - 32 * w -: 32] = it.word_value;
          else if (w == 4) begin
            a_dport[e] = it.word_value[15:0]; a_proto[e] = it.word_value[23:16];
            a_fam[e] = it.word_value[24]; a_val[e] = it.word_value[25];
          end else if (w == 5) a_exp[e][31:0] = it.word_value;
          else a_exp[e][63:32] = it.word_value;
        end
        default: begin
          if (nbytes < 127) begin
            capture(nbytes, it.pkt_byte);
            nbytes++;
          end
          if (it.pkt_last) begin
            r = verdict(nbytes);
            v.reason = r;
            v.drop = (r >= RSN_NOPORTS);
            verdicts.push_back(v);
            clear_frame();
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      seen++;
      if (verdicts.size() == 0) begin
        report($sformatf("verdict drop=%0d reason=%0d with none expected",
                         got.drop, got.reason));
      end else begin
        want = verdicts.pop_front();
        if (got.drop !== want.drop)
          report($sformatf("verdict %0d: drop %0d, expected %0d", seen, got.drop, want.drop));
        if (got.reason !== want.reason)
          report($sformatf("verdict %0d: reason %0d, expected %0d",
                           seen, got.reason, want.reason));
      end
    endtask
  endclass

  logic        clk, rst_n, start, busy, out_strobe, cfg_we;
  in_item_t    in_item;
  out_item_t   out_item;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  gate_scoreboard sb;
  int unsigned cycles;
  int          n_items;
  logic [127:0] v4_dst[6], v6_dst[4], v4_src[3], v6_src[3];

  default_deny_packet_gate dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL default_deny_packet_gate");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  function automatic in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[57:0];
  endfunction

  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    n_items++;
  endtask

  task automatic pause();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.verdicts.size() > 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] v[5]);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk);
      sb.set_reg(3'(i), v[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(req_e kind, int e, logic [2:0] w, logic [31:0] v);
    in_item_t it;
    it = noise_item();
    it.req_type = kind;
    it.entry_index = 12'(e);
    it.word_index = w;
    it.word_value = v;
    send_item(it);
    pause();
  endtask

  task automatic write_prot(int e, bit fam, logic [127:0] a, bit valid);
    for (int w = 0; w < 4; w++) send_word(REQ_PROT, e, 3'(w), a[127 - 32 * w -: 32]);
    send_word(REQ_PROT, e, WI_CTRL, {6'd0, valid, fam, 24'($urandom)});
  endtask

  task automatic write_allow(int e, bit fam, logic [127:0] a, logic [7:0] pr,
                             logic [15:0] dp, logic [63:0] ex, bit valid);
    for (int w = 0; w < 4; w++) send_word(REQ_ALLOW, e, 3'(w), a[127 - 32 * w -: 32]);
    send_word(REQ_ALLOW, e, WI_EXPLO, ex[31:0]);
    send_word(REQ_ALLOW, e, WI_EXPHI, ex[63:32]);
    send_word(REQ_ALLOW, e, WI_CTRL, {6'($urandom) & 6'd0, valid, fam, pr, dp});
  endtask

  function automatic logic [63:0] pick_expiry();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return sb.clk_ns + 64'($urandom_range(0, 400)) * sb.tick_step;
      2: return 64'd1;
      default: return '1;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 6))
      0: return sb.spa;
      1: return sb.tunnel;
      2: return sb.shell;
      3: return 16'd80;
      4: return 16'd443;
      5: return 16'd53;
      default: return 16'($urandom);
    endcase
  endfunction

  // Protected entries 0-6 hold pool destinations; 7 is written with its valid bit clear.
  task automatic program_tables();
    bit fam;
    for (int i = 0; i < 4; i++) write_prot(i, 1'b0, v4_dst[i], 1'b1);
    for (int i = 0; i < 3; i++) write_prot(4 + i, 1'b1, v6_dst[i], 1'b1);
    write_prot(7, 1'b0, v4_dst[4], 1'b0);
    send_word(REQ_PROT, $urandom_range(P_ENTRIES, 4095), 3'd0, v4_dst[5][127:96]);
    send_word(REQ_PROT, 9, WI_EXPLO, $urandom);
    send_word(REQ_PROT, 9, 3'd7, $urandom);
    send_word(REQ_ALLOW, 10, 3'd7, $urandom);
    for (int k = 3; k < 24; k++) begin
      fam = $urandom_range(0, 1);
      write_allow(k, fam, fam ? v6_src[$urandom_range(0, 2)] : v4_src[$urandom_range(0, 2)],
                  $urandom_range(0, 1) ? PR_TCP : PR_UDP,
                  ($urandom_range(0, 2) == 0) ? 16'd80 : ($urandom_range(0, 1) ? 16'd443
                                                                              : 16'd53),
                  pick_expiry(), $urandom_range(0, 9) != 0);
    end
  endtask

  function automatic void build_frame(ref logic [7:0] q[$], input int fam,
                                      input logic [7:0] pr, input logic [127:0] sa,
                                      input logic [127:0] da, input logic [15:0] dp,
                                      input logic [3:0] hl, input logic [12:0] fo,
                                      input int pay);
    logic [15:0] et;
    q.delete();
    repeat (12) q.push_back(8'($urandom));
    if (fam == 1) et = ETH_IPV4;
    else if (fam == 2) et = ETH_IPV6;
    else begin
      et = 16'($urandom);
      if (et == ETH_IPV4 || et == ETH_IPV6) et = 16'h88B5;
    end
    q.push_back(et[15:8]);
    q.push_back(et[7:0]);
    if (fam == 1) begin
      q.push_back({4'h4, hl});
      repeat (5) q.push_back(8'($urandom));
      q.push_back({3'($urandom), fo[12:8]});
      q.push_back(fo[7:0]);
      q.push_back(8'($urandom));
      q.push_back(pr);
      repeat (2) q.push_back(8'($urandom));
      for (int k = 0; k < 4; k++) q.push_back(sa[127 - 8 * k -: 8]);
      for (int k = 0; k < 4; k++) q.push_back(da[127 - 8 * k -: 8]);
      while (q.size() < 14 + hl * 4) q.push_back(8'($urandom));
    end else if (fam == 2) begin
      q.push_back(8'h60);
      repeat (5) q.push_back(8'($urandom));
      q.push_back(pr);
      q.push_back(8'($urandom));
      for (int k = 0; k < 16; k++) q.push_back(sa[127 - 8 * k -: 8]);
      for (int k = 0; k < 16; k++) q.push_back(da[127 - 8 * k -: 8]);
    end
    if (fam != 0) begin
      repeat (2) q.push_back(8'($urandom));
      q.push_back(dp[15:8]);
      q.push_back(dp[7:0]);
      repeat ((pr == PR_TCP) ? 16 : 4) q.push_back(8'($urandom));
    end
    repeat (pay) q.push_back(8'($urandom));
  endfunction

  task automatic send_frame(logic [7:0] q[$], bit burst);
    in_item_t it;
    bit fam;
    for (int i = 0; i < q.size(); i++) begin
      // ticks and table words slipped into a frame must not disturb it
      if (!burst && $urandom_range(0, 99) < 4) begin
        if ($urandom_range(0, 9) < 4) begin
          it = noise_item();
          it.req_type = REQ_TICK;
          send_item(it);
        end else if ($urandom_range(0, 1)) begin
          fam = $urandom_range(0, 1);
          send_word(REQ_ALLOW, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(24, 31),
                    3'($urandom_range(0, 7)),
                    $urandom_range(0, 1) ? {6'd0, 1'b1, fam, PR_TCP, 16'd80}
                                         : 32'($urandom));
        end else begin
          send_word(REQ_PROT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(8, 15),
                    3'($urandom_range(0, 7)), $urandom);
        end
      end
      it = noise_item();
      it.req_type = REQ_BYTE;
      it.pkt_byte = q[i];
      it.pkt_last = (i == q.size() - 1);
      send_item(it);
      if (!burst) pause();
    end
  endtask

  task automatic random_frame();
    logic [7:0] q[$];
    int fam, r, pay;
    logic [7:0] pr;
    logic [127:0] sa, da;
    r = $urandom_range(0, 99);
    fam = (r < 8) ? 0 : (r < 60) ? 1 : 2;
    r = $urandom_range(0, 9);
    pr = (r < 4) ? PR_TCP : (r < 7) ? PR_UDP : (r == 7) ? PR_ICMP : (r == 8) ? PR_ICMP6
                                                                           : 8'($urandom);
    if (fam == 2) begin
      sa = v6_src[$urandom_range(0, 2)];
      da = v6_dst[$urandom_range(0, 3)];
    end else begin
      sa = v4_src[$urandom_range(0, 2)];
      da = v4_dst[$urandom_range(0, 5)];
    end
    if ($urandom_range(0, 9) == 0) sa = {$urandom, $urandom, $urandom, $urandom};
    pay = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 16);
    build_frame(q, fam, pr, sa, da, pick_port(),
                ($urandom_range(0, 99) < 85) ? 4'd5 : 4'($urandom_range(0, 15)),
                ($urandom_range(0, 99) < 85) ? 13'd0 : 13'($urandom), pay);
    if ($urandom_range(0, 99) < 15) q = q[0:$urandom_range(0, q.size() - 1)];
    send_frame(q, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [7:0] q[$];
    logic [31:0] regs[5];
    in_item_t tk;
    int items0;

    sb = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SPA;
    cfg_data <= '0;
    cycles = 0;
    n_items = 0;
    for (int i = 0; i < 6; i++) v4_dst[i] = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < 4; i++) v6_dst[i] = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < 3; i++) begin
      v4_src[i] = {$urandom, $urandom, $urandom, $urandom};
      v6_src[i] = {$urandom, $urandom, $urandom, $urandom};
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers may be written during the clearing pass
    regs = '{32'd62201, 32'd41641, 32'd22, 32'd0, 32'd1};
    write_regs(regs);
    program_tables();
    write_allow(0, 1'b0, v4_src[0], PR_TCP, 16'd80, 64'd0, 1'b1);
    write_allow(1, 1'b0, v4_src[1], PR_UDP, 16'd53, sb.clk_ns + 64'd5, 1'b1);
    write_allow(2, 1'b1, v6_src[0], PR_TCP, 16'd443, '1, 1'b1);

    // directed frames: truncation, carve-outs, protection, allow entries
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[0], 16'd80, 4'd5, 13'd0, 0);
    send_frame(q[0:4], 0);
    build_frame(q, 0, PR_TCP, v4_src[0], v4_dst[0], 16'd80, 4'd5, 13'd0, 50);
    send_frame(q, 0);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[0], 16'd80, 4'd4, 13'd0, 0);
    send_frame(q, 0);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[0], 16'd80, 4'd15, 13'd0, 0);
    send_frame(q[0:49], 0);
    build_frame(q, 1, PR_UDP, v4_src[2], v4_dst[1], sb.spa, 4'd5, 13'd0, 3);
    send_frame(q, 0);
    build_frame(q, 1, PR_TCP, v4_src[2], v4_dst[1], sb.shell, 4'd6, 13'd0, 0);
    send_frame(q, 1);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[5], 16'd80, 4'd5, 13'd0, 0);
    send_frame(q, 0);
    build_frame(q, 1, PR_ICMP, v4_src[0], v4_dst[0], 16'd0, 4'd5, 13'd0, 8);
    send_frame(q, 0);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[2], 16'd80, 4'd5, 13'h1FFF, 0);
    send_frame(q, 0);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[3], 16'd80, 4'd5, 13'd0, 4);
    send_frame(q, 0);
    build_frame(q, 1, PR_UDP, v4_src[1], v4_dst[0], 16'd53, 4'd5, 13'd0, 0);
    send_frame(q, 0);
    build_frame(q, 1, PR_TCP, v4_src[2], v4_dst[0], 16'd443, 4'd5, 13'd0, 0);
    send_frame(q, 0);
    tk = noise_item();
    tk.req_type = REQ_TICK;
    repeat (10) send_item(tk);
    build_frame(q, 1, PR_UDP, v4_src[1], v4_dst[0], 16'd53, 4'd5, 13'd0, 0);
    send_frame(q, 0);
    build_frame(q, 2, PR_UDP, v6_src[1], v6_dst[3], sb.tunnel, 4'd5, 13'd0, 0);
    send_frame(q, 0);
    build_frame(q, 2, PR_ICMP6, v6_src[1], v6_dst[0], 16'd0, 4'd5, 13'd0, 8);
    send_frame(q, 0);
    build_frame(q, 2, PR_TCP, v6_src[0], v6_dst[1], 16'd443, 4'd5, 13'd0, 0);
    send_frame(q, 0);
    build_frame(q, 2, PR_TCP, v6_src[0], v6_dst[1], 16'd443, 4'd5, 13'd0, 0);
    send_frame(q[0:49], 0);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[0], 16'd80, 4'd5, 13'd0, 150);
    send_frame(q, 1);
    build_frame(q, 1, PR_TCP, v4_src[0], v4_dst[0], 16'd80, 4'd5, 13'd0, 0);
    send_frame(q[0:43], 0);

    // random phases, each under its own register setting; the remaining
    // item budget is split evenly across them
    items0 = n_items;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: regs = '{32'd62201, 32'd41641, 32'd22, 32'd0, 32'd1};
        1: regs = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd1};
        2: regs = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd0, 32'hFFFFFFFF};
        3: regs = '{$urandom, $urandom, $urandom, 32'd1, $urandom_range(1, 1000)};
        default: regs = '{32'd443, $urandom, 32'd80, $urandom, 32'd100};
      endcase
      write_regs(regs);
      @(posedge clk);
      do random_frame();
      while (n_items < items0 + (N_ITEMS - items0) * (ph + 1) / 5);
    end

    drain();
    repeat (2 * SCAN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts.size() == 0) $display("PASS default_deny_packet_gate");
    else $display("FAIL default_deny_packet_gate");
    $finish;
  end

endmodule
